// ----- src/pimt_pkg.sv -----
// Shared types and constants for the peer id map table.
// Used by pimt_front, pimt_back and peer_id_map_table_unit; no dependencies.
package pimt_pkg;

   localparam int MAX_PEERS    = 32;
   localparam int NUM_PEER_IDS = 2048;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int VDEV_W   = 4;
   localparam int ADDR_W   = 48;
   localparam int PID_W    = 11;
   localparam int STATUS_W = 2;
   localparam int SLOTF_W  = 5;

   // derived storage widths
   localparam int SLOT_AW = $clog2(MAX_PEERS);
   localparam int ENT_W   = $clog2(MAX_PEERS + 1);
   localparam int ID_AW   = $clog2(NUM_PEER_IDS);
   localparam int CNT_W   = $clog2(NUM_PEER_IDS + 1);

   // front to back queue
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_MAP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNMAP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_ID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

   typedef enum logic [1:0] {
      OP_MAP,
      OP_UNMAP,
      OP_LOOKUP,
      OP_REJECT
   } pimt_kind_type;

   typedef struct packed {
      pimt_kind_type        kind;
      logic [STATUS_W-1:0]  rej_status;
      logic [VDEV_W-1:0]    vdev;
      logic [ADDR_W-1:0]    addr;
      logic [ID_AW-1:0]     id;
   } pimt_op_type;

   typedef struct packed {
      logic        valid;
      pimt_op_type op;
   } pimt_qout_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } pimt_bstat_type;

endpackage

// ----- src/pimt_front.sv -----
// Front end of the peer id map table: decodes and range-checks requests,
// then holds them in a short queue for the back end. Depends on pimt_pkg.
module pimt_front import pimt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [VDEV_W-1:0]    req_vdev,
   input  logic [ADDR_W-1:0]    req_mac_addr,
   input  logic [PID_W-1:0]     req_peer_id,
   input  pimt_bstat_type       bstat,
   output pimt_qout_type        qout
);

   pimt_op_type          q_mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]      cnt_ff, cnt_in;
   pimt_op_type          op_in;
   logic                 id_ok;
   logic                 push;
   logic                 pop;

   // classify the request
   always_comb begin
      id_ok            = 32'(req_peer_id) < NUM_PEER_IDS;
      op_in.vdev       = req_vdev;
      op_in.addr       = req_mac_addr;
      op_in.id         = ID_AW'(req_peer_id);
      op_in.rej_status = ST_NOT_FOUND;
      case (req_cmd)
         CMD_MAP: begin
            op_in.kind = id_ok ? OP_MAP : OP_REJECT;
            op_in.rej_status = ST_UNKNOWN_ID;
         end
         CMD_UNMAP: begin
            op_in.kind = id_ok ? OP_UNMAP : OP_REJECT;
            op_in.rej_status = ST_UNKNOWN_ID;
         end
         CMD_LOOKUP: begin
            op_in.kind = OP_LOOKUP;
         end
         default: begin
            op_in.kind = OP_REJECT;
         end
      endcase
   end

   assign req_ready  = (cnt_ff != Q_CW'(Q_DEPTH)) && !bstat.clearing;
   assign push       = req_valid && req_ready;
   assign pop        = bstat.pop && (cnt_ff != '0);
   assign qout.valid = cnt_ff != '0;
   assign qout.op    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == Q_DEPTH - 1) ? '0 : wr_ptr_ff + Q_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == Q_DEPTH - 1) ? '0 : rd_ptr_ff + Q_AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + Q_CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

// ----- src/pimt_back.sv -----
// Back end of the peer id map table: key search, id-to-slot memory,
// per-slot id counts and the result register. Depends on pimt_pkg.
module pimt_back import pimt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pimt_qout_type        qout,
   output pimt_bstat_type       bstat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOTF_W-1:0]   rsp_slot,
   output logic                 rsp_created,
   output logic                 rsp_freed
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_RESOLVE,
      S_WOLD,
      S_WNEW
   } state_type;

   state_type            state_ff;

   // peer table
   logic                 valid_ff [MAX_PEERS];
   logic [VDEV_W-1:0]    vdev_ff  [MAX_PEERS];
   logic [ADDR_W-1:0]    addr_ff  [MAX_PEERS];

   // memories
   logic [ENT_W-1:0]     id_mem  [NUM_PEER_IDS];
   logic [CNT_W-1:0]     cnt_mem [MAX_PEERS];

   logic [ID_AW-1:0]     clr_ff;
   pimt_op_type          op_ff;
   logic [MAX_PEERS-1:0] match_ff, match_in;
   logic [ENT_W-1:0]     id_rd_ff;
   logic [CNT_W-1:0]     cnt_a_ff, cnt_b_ff;
   logic [SLOT_AW-1:0]   s_ff, o_ff;
   logic                 created_ff, same_ff, move_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [SLOTF_W-1:0]   rsp_slot_ff;
   logic                 rsp_created_ff, rsp_freed_ff;

   logic                 out_free;
   logic                 hit, free_any;
   logic [SLOT_AW-1:0]   hit_idx, free_idx, map_slot, old_idx;
   logic [ENT_W-1:0]     map_ent;
   logic                 ent_ok, unmap_ok;
   logic [CNT_W-1:0]     dec_a;

   logic                 fin_here, fin_go;
   logic [STATUS_W-1:0]  fin_status;
   logic [SLOT_AW-1:0]   fin_slot;
   logic                 fin_created, fin_freed;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      for (int i = 0; i < MAX_PEERS; i++) begin
         match_in[i] = valid_ff[i] && (vdev_ff[i] == op_ff.vdev) && (addr_ff[i] == op_ff.addr);
      end
      // lowest matching and lowest free slot
      hit      = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = MAX_PEERS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit     = 1'b1;
            hit_idx = SLOT_AW'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_AW'(i);
         end
      end
      map_slot = hit ? hit_idx : free_idx;
      map_ent  = ENT_W'(map_slot) + ENT_W'(1);
      old_idx  = SLOT_AW'(id_rd_ff - ENT_W'(1));
      ent_ok   = (id_rd_ff != '0) && (32'(id_rd_ff) <= MAX_PEERS);
      unmap_ok = ent_ok && valid_ff[old_idx];
      dec_a    = (cnt_a_ff == '0) ? '0 : cnt_a_ff - CNT_W'(1);
   end

   // result of the current state, if it finishes the item
   always_comb begin
      fin_here    = 1'b0;
      fin_status  = ST_OK;
      fin_slot    = '0;
      fin_created = 1'b0;
      fin_freed   = 1'b0;
      case (state_ff)
         S_LOOK: begin
            if (op_ff.kind == OP_REJECT) begin
               fin_here   = 1'b1;
               fin_status = op_ff.rej_status;
            end
         end
         S_RESOLVE: begin
            case (op_ff.kind)
               OP_LOOKUP: begin
                  fin_here   = 1'b1;
                  fin_status = hit ? ST_OK : ST_NOT_FOUND;
                  fin_slot   = hit ? hit_idx : '0;
               end
               OP_MAP: begin
                  if (!hit && !free_any) begin
                     fin_here   = 1'b1;
                     fin_status = ST_FULL;
                  end
               end
               OP_UNMAP: begin
                  if (!unmap_ok) begin
                     fin_here   = 1'b1;
                     fin_status = ST_UNKNOWN_ID;
                  end
               end
               default: begin
                  fin_here   = 1'b1;
                  fin_status = ST_NOT_FOUND;
               end
            endcase
         end
         S_WOLD: begin
            if (op_ff.kind == OP_UNMAP) begin
               fin_here  = 1'b1;
               fin_slot  = o_ff;
               fin_freed = dec_a == '0;
            end
         end
         S_WNEW: begin
            fin_here    = 1'b1;
            fin_slot    = s_ff;
            fin_created = created_ff;
         end
         default: begin
            fin_here = 1'b0;
         end
      endcase
      fin_go = fin_here && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PEERS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (fin_go) begin
            rsp_valid_ff   <= 1'b1;
            rsp_status_ff  <= fin_status;
            rsp_slot_ff    <= SLOTF_W'(fin_slot);
            rsp_created_ff <= fin_created;
            rsp_freed_ff   <= fin_freed;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               id_mem[clr_ff] <= '0;
               clr_ff         <= clr_ff + ID_AW'(1);
               if (32'(clr_ff) == NUM_PEER_IDS - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (qout.valid) begin
                  op_ff    <= qout.op;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               match_ff <= match_in;
               id_rd_ff <= id_mem[op_ff.id];
               if (fin_here) begin
                  if (fin_go) begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_RESOLVE;
               end
            end
            S_RESOLVE: begin
               if (fin_here) begin
                  if (fin_go) begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  o_ff     <= old_idx;
                  cnt_a_ff <= cnt_mem[old_idx];
                  state_ff <= S_WOLD;
                  if (op_ff.kind == OP_MAP) begin
                     s_ff       <= map_slot;
                     created_ff <= !hit;
                     same_ff    <= id_rd_ff == map_ent;
                     move_ff    <= (id_rd_ff != map_ent) && ent_ok;
                     cnt_b_ff   <= cnt_mem[map_slot];
                     if (!hit) begin
                        valid_ff[map_slot] <= 1'b1;
                        vdev_ff[map_slot]  <= op_ff.vdev;
                        addr_ff[map_slot]  <= op_ff.addr;
                     end
                  end
               end
            end
            S_WOLD: begin
               if (op_ff.kind == OP_UNMAP) begin
                  if (fin_go) begin
                     id_mem[op_ff.id] <= '0;
                     cnt_mem[o_ff]    <= dec_a;
                     if (dec_a == '0) begin
                        valid_ff[o_ff] <= 1'b0;
                     end
                     state_ff <= S_IDLE;
                  end
               end else begin
                  // release the id from its previous peer, drop that peer when empty
                  if (move_ff) begin
                     cnt_mem[o_ff] <= dec_a;
                     if (dec_a == '0) begin
                        valid_ff[o_ff] <= 1'b0;
                     end
                  end
                  if (!same_ff) begin
                     id_mem[op_ff.id] <= ENT_W'(s_ff) + ENT_W'(1);
                  end
                  state_ff <= S_WNEW;
               end
            end
            S_WNEW: begin
               if (fin_go) begin
                  if (!same_ff) begin
                     cnt_mem[s_ff] <= created_ff ? CNT_W'(1) : cnt_b_ff + CNT_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign bstat.clearing = state_ff == S_CLEAR;
   assign bstat.pop      = (state_ff == S_IDLE) && qout.valid;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_created = rsp_created_ff;
   assign rsp_freed   = rsp_freed_ff;

endmodule

// ----- src/peer_id_map_table_unit.sv -----
// The back end takes one item at a time, stepped by its sequencer (search, memory
// read, count update), and takes no new item before the last one is through; a
// two-entry queue lets requests queue up meanwhile. After reset the id-to-slot
// memory is swept clear, one entry per cycle, and no request is accepted meanwhile.
module peer_id_map_table_unit import pimt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [VDEV_W-1:0]    req_vdev,
   input  logic [ADDR_W-1:0]    req_mac_addr,
   input  logic [PID_W-1:0]     req_peer_id,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOTF_W-1:0]   rsp_slot,
   output logic                 rsp_created,
   output logic                 rsp_freed
);

   pimt_qout_type  qout;
   pimt_bstat_type bstat;

   pimt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_vdev     (req_vdev),
      .req_mac_addr (req_mac_addr),
      .req_peer_id  (req_peer_id),
      .bstat        (bstat),
      .qout         (qout)
   );

   pimt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qout        (qout),
      .bstat       (bstat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_created (rsp_created),
      .rsp_freed   (rsp_freed)
   );

endmodule
